FILE: src/vrs_pkg.sv
package vrs_pkg;

    // Field widths
    localparam int REQ_W    = 3;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;

    // Default sizing
    localparam int STORE_BYTES_DEF  = 1024;
    localparam int MAX_RECORD_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 4;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_PUSH_START = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_DATA  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SEQ   = 2'd3;

endpackage

FILE: src/vrs_store.sv
module vrs_store #(
    parameter int DEPTH = vrs_pkg::STORE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [vrs_pkg::BYTE_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    input  logic                        rzero,
    output logic [vrs_pkg::BYTE_W-1:0]  rdata
);
    import vrs_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_reg;
    logic              zero_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held between reads; out-of-range reads return zero
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_reg   <= mem[raddr];
            zero_reg <= rzero;
        end
    end

    assign rdata = zero_reg ? '0 : rd_reg;

endmodule

FILE: src/variable_record_stack_core.sv
// Stack of variable-length byte records in a single-port-read, single-port-write byte memory
// growing down from the top end; each record is its data bytes with a little-endian length
// header below them. Push-start, push-data, clear and error requests are answered from the
// idle state; the request that completes a record is followed by the header writes before
// the next request is taken. Pop and peek fetch the header and then the data one byte per
// cycle through the memory's read port, and result backpressure stretches this. A finished
// result waits in an output register; the next request is taken only once that result is
// being accepted or has left.
module variable_record_stack_core #(
    parameter int STORE_BYTES  = vrs_pkg::STORE_BYTES_DEF,
    parameter int MAX_RECORD   = vrs_pkg::MAX_RECORD_DEF,
    parameter int HEADER_BYTES = vrs_pkg::HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] record_len, [14:7] data_byte, [21:15] max_len, [23:22] zero
    input  logic [23:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [8] is_empty, [19:9] free_bytes, [23:20] zero
    output logic [23:0] m_tdata,
    // [1:0] status, [2] byte_valid
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import vrs_pkg::*;

    localparam int TW  = $clog2(STORE_BYTES + 1);
    localparam int AW  = $clog2(STORE_BYTES);
    localparam int HW  = 8 * HEADER_BYTES;
    localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int CW  = ((TW > LEN_W) ? TW : LEN_W) + 1;
    localparam int EW  = CW + 1;
    localparam int SW  = ((HW > EW) ? HW : EW) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HWR   = 3'd1;
    localparam logic [2:0] S_HRD   = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_BYTES = 3'd4;

    localparam logic [TW-1:0]    TOP_EMPTY = TW'(STORE_BYTES);
    localparam logic [HIW-1:0]   HDR_LAST  = HIW'(HEADER_BYTES - 1);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_RECORD);

    // Unpack request
    logic [REQ_W-1:0] req_type;
    logic [LEN_W-1:0] record_len;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] max_len;

    assign req_type   = s_tuser;
    assign record_len = s_tdata[6:0];
    assign data_byte  = s_tdata[14:7];
    assign max_len    = s_tdata[21:15];

    // Registers
    logic [2:0]          state_reg,     state_next;
    logic [TW-1:0]       top_reg,       top_next;
    logic                push_open_reg, push_open_next;
    logic [LEN_W-1:0]    push_rem_reg,  push_rem_next;
    logic [LEN_W-1:0]    push_len_reg,  push_len_next;
    logic [AW-1:0]       wr_idx_reg,    wr_idx_next;
    logic [AW-1:0]       hbase_reg,     hbase_next;
    logic [HIW-1:0]      hcnt_reg,      hcnt_next;
    logic [HIW-1:0]      hcap_reg,      hcap_next;
    logic                hpend_reg,     hpend_next;
    logic                hdone_reg,     hdone_next;
    logic [HW-1:0]       stored_reg,    stored_next;
    logic [LEN_W-1:0]    mlen_reg,      mlen_next;
    logic                pop_reg,       pop_next;
    logic [EW-1:0]       base_reg,      base_next;
    logic [LEN_W-1:0]    n_reg,         n_next;
    logic [LEN_W-1:0]    icnt_reg,      icnt_next;
    logic                a_valid_reg,   a_valid_next;
    logic                a_last_reg,    a_last_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                out_bvalid_reg, out_bvalid_next;
    logic                out_last_reg,  out_last_next;
    logic                out_empty_reg, out_empty_next;
    logic [FREE_W-1:0]   out_free_reg,  out_free_next;

    // Memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_rzero;
    logic [BYTE_W-1:0] mem_rdata;

    vrs_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rzero (mem_rzero),
        .rdata (mem_rdata)
    );

    // Helpers
    logic          out_free_slot;
    logic          accept;
    logic [CW-1:0] need;
    logic [CW-1:0] hbase_full;
    logic [HW-1:0] len_hdr;
    logic [EW-1:0] rd_addr_full;
    logic [LEN_W-1:0] mlen_clamp;
    logic [LEN_W-1:0] n_calc;
    logic [SW-1:0] new_top;
    logic          a_take;

    assign out_free_slot = !out_valid_reg || m_tready;
    assign s_tready      = (state_reg == S_IDLE) && out_free_slot;
    assign accept        = s_tvalid && s_tready;
    assign need          = CW'(record_len) + CW'(HEADER_BYTES);
    assign len_hdr       = HW'(push_len_reg);
    assign mlen_clamp    = (mlen_reg > MAX_LEN) ? MAX_LEN : mlen_reg;
    assign n_calc        = (stored_reg < HW'(mlen_clamp)) ? LEN_W'(stored_reg) : mlen_clamp;
    assign new_top       = SW'(base_reg) + SW'(stored_reg);
    assign a_take        = a_valid_reg && out_free_slot;

    always_comb begin
        state_next      = state_reg;
        top_next        = top_reg;
        push_open_next  = push_open_reg;
        push_rem_next   = push_rem_reg;
        push_len_next   = push_len_reg;
        wr_idx_next     = wr_idx_reg;
        hbase_next      = hbase_reg;
        hcnt_next       = hcnt_reg;
        hcap_next       = hcap_reg;
        hpend_next      = 1'b0;
        hdone_next      = hdone_reg;
        stored_next     = stored_reg;
        mlen_next       = mlen_reg;
        pop_next        = pop_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        icnt_next       = icnt_reg;
        a_valid_next    = a_valid_reg;
        a_last_next     = a_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_free_next   = out_free_reg;
        hbase_full      = '0;
        rd_addr_full    = '0;
        mem_we          = 1'b0;
        mem_waddr       = wr_idx_reg;
        mem_wdata       = data_byte;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_rzero       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // default single result; fields finalized below
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_byte_next   = '0;
                    out_bvalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    case (req_type)
                        REQ_PUSH_START: begin
                            if (push_open_reg) begin
                                out_status_next = ST_SEQ;
                            end else if (record_len > MAX_LEN || CW'(top_reg) < need) begin
                                out_status_next = ST_FULL;
                            end else begin
                                push_len_next = record_len;
                                push_rem_next = record_len;
                                wr_idx_next   = AW'(CW'(top_reg) - CW'(record_len));
                                push_open_next = 1'b1;
                                if (record_len == '0) begin
                                    // empty record: header goes in at once
                                    hbase_full     = CW'(top_reg) - CW'(HEADER_BYTES);
                                    hbase_next     = AW'(hbase_full);
                                    top_next       = TW'(hbase_full);
                                    push_open_next = 1'b0;
                                    push_rem_next  = '0;
                                    hcnt_next      = '0;
                                    state_next     = S_HWR;
                                end
                            end
                        end
                        REQ_PUSH_DATA: begin
                            if (!push_open_reg) begin
                                out_status_next = ST_SEQ;
                            end else begin
                                mem_we        = 1'b1;
                                wr_idx_next   = wr_idx_reg + 1'b1;
                                push_rem_next = push_rem_reg - 1'b1;
                                if (push_rem_reg == LEN_W'(1)) begin
                                    // last byte: close the record
                                    hbase_full     = CW'(top_reg) - CW'(push_len_reg)
                                                   - CW'(HEADER_BYTES);
                                    hbase_next     = AW'(hbase_full);
                                    top_next       = TW'(hbase_full);
                                    push_open_next = 1'b0;
                                    hcnt_next      = '0;
                                    state_next     = S_HWR;
                                end
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            if (push_open_reg) begin
                                out_status_next = ST_SEQ;
                            end else if (top_reg == TOP_EMPTY) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                // fetch header, result comes later
                                out_valid_next = 1'b0;
                                pop_next       = (req_type == REQ_POP);
                                mlen_next      = max_len;
                                base_next      = EW'(top_reg) + EW'(HEADER_BYTES);
                                stored_next    = '0;
                                hcnt_next      = '0;
                                hdone_next     = 1'b0;
                                state_next     = S_HRD;
                            end
                        end
                        REQ_CLEAR: begin
                            top_next       = TOP_EMPTY;
                            push_open_next = 1'b0;
                            push_rem_next  = '0;
                            push_len_next  = '0;
                            wr_idx_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                    out_empty_next = (top_next == TOP_EMPTY);
                    out_free_next  = FREE_W'(top_next);
                end
            end

            S_HWR: begin
                // write one header byte per cycle, lowest byte first
                mem_we    = 1'b1;
                mem_waddr = hbase_reg + AW'(hcnt_reg);
                mem_wdata = len_hdr[8*hcnt_reg +: 8];
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == HDR_LAST) begin
                    state_next = S_IDLE;
                end
            end

            S_HRD: begin
                // collect the byte read last cycle
                if (hpend_reg) begin
                    stored_next[8*hcap_reg +: 8] = mem_rdata;
                    if (hcap_reg == HDR_LAST) begin
                        state_next = S_CALC;
                    end
                end
                // issue the next header read
                if (!hdone_reg) begin
                    rd_addr_full = EW'(top_reg) + EW'(hcnt_reg);
                    mem_re       = 1'b1;
                    mem_raddr    = AW'(rd_addr_full);
                    mem_rzero    = rd_addr_full >= EW'(STORE_BYTES);
                    hpend_next   = 1'b1;
                    hcap_next    = hcnt_reg;
                    hcnt_next    = hcnt_reg + 1'b1;
                    hdone_next   = (hcnt_reg == HDR_LAST);
                end
            end

            S_CALC: begin
                n_next    = n_calc;
                icnt_next = '0;
                if (n_calc != '0 || out_free_slot) begin
                    // drop the record on pop, saturating at the store end
                    if (pop_reg) begin
                        top_next = (new_top > SW'(STORE_BYTES)) ? TOP_EMPTY : TW'(new_top);
                    end
                    if (n_calc == '0) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_byte_next   = '0;
                        out_bvalid_next = 1'b0;
                        out_last_next   = 1'b1;
                        out_empty_next  = (top_next == TOP_EMPTY);
                        out_free_next   = FREE_W'(top_next);
                        state_next      = S_IDLE;
                    end else begin
                        a_valid_next = 1'b0;
                        state_next   = S_BYTES;
                    end
                end
            end

            S_BYTES: begin
                // move read data into the output register
                if (a_take) begin
                    a_valid_next    = 1'b0;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_byte_next   = mem_rdata;
                    out_bvalid_next = 1'b1;
                    out_last_next   = a_last_reg;
                    out_empty_next  = (top_reg == TOP_EMPTY);
                    out_free_next   = FREE_W'(top_reg);
                    if (a_last_reg) begin
                        state_next = S_IDLE;
                    end
                end
                // advance the read pointer when the read stage frees up
                if (icnt_reg < n_reg && (!a_valid_reg || a_take)) begin
                    rd_addr_full = base_reg + EW'(icnt_reg);
                    mem_re       = 1'b1;
                    mem_raddr    = AW'(rd_addr_full);
                    mem_rzero    = rd_addr_full >= EW'(STORE_BYTES);
                    a_valid_next = 1'b1;
                    a_last_next  = (icnt_reg == n_reg - 1'b1);
                    icnt_next    = icnt_reg + 1'b1;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            top_reg       <= TOP_EMPTY;
            push_open_reg <= 1'b0;
            push_rem_reg  <= '0;
            push_len_reg  <= '0;
            wr_idx_reg    <= '0;
            hpend_reg     <= 1'b0;
            hdone_reg     <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            push_open_reg <= push_open_next;
            push_rem_reg  <= push_rem_next;
            push_len_reg  <= push_len_next;
            wr_idx_reg    <= wr_idx_next;
            hpend_reg     <= hpend_next;
            hdone_reg     <= hdone_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        hbase_reg      <= hbase_next;
        hcnt_reg       <= hcnt_next;
        hcap_reg       <= hcap_next;
        stored_reg     <= stored_next;
        mlen_reg       <= mlen_next;
        pop_reg        <= pop_next;
        base_reg       <= base_next;
        n_reg          <= n_next;
        icnt_reg       <= icnt_next;
        a_last_reg     <= a_last_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_free_reg   <= out_free_next;
    end

    // Result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_free_reg, out_empty_reg, out_byte_reg};
    assign m_tuser  = {out_bvalid_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("request taken while busy");

    a_top_range: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_EMPTY)
        else $error("top beyond store end");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bvalid_reg) |-> out_status_reg == ST_OK)
        else $error("record byte with error status");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_open_reg |-> (push_rem_reg != '0 && push_rem_reg <= push_len_reg))
        else $error("open push with bad remaining count");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BYTES |-> icnt_reg <= n_reg)
        else $error("read pointer past transfer length");

endmodule

FILE: bench/variable_record_stack_core_tb.sv
`timescale 1ns / 100ps

module variable_record_stack_core_tb;

    import vrs_pkg::*;

    localparam int STORE       = STORE_BYTES_DEF;
    localparam int MAX_REC     = MAX_RECORD_DEF;
    localparam int HDR         = HEADER_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam int RANDOM_REQS = 220;

    // Request kinds the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                last_res;
        logic                is_empty;
        logic [FREE_W-1:0]   free_bytes;
    } stack_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow of the stack contents and push state
    logic [BYTE_W-1:0] mem_image [STORE];
    int unsigned       stack_top;
    bit                push_active;
    int unsigned       push_left;
    int unsigned       push_len;
    int unsigned       write_ptr;

    stack_result_t expected_results[$];
    int            mismatch_count = 0;
    bit            burst_mode = 1'b0;
    int            hold_requests = 0;

    variable_record_stack_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, none in burst mode
    function automatic int pick_gap();
        int r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(16, 32);
    endfunction

    // ------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------
    task automatic model_clear();
        stack_top   = STORE;
        push_active = 1'b0;
        push_left   = 0;
        push_len    = 0;
        write_ptr   = 0;
    endtask

    function automatic logic [BYTE_W-1:0] mem_at(int unsigned addr);
        return (addr < STORE) ? mem_image[addr] : '0;
    endfunction

    task automatic queue_result(input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] b,
                                input logic valid, input logic last_res);
        stack_result_t r;
        r.status     = st;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.last_res   = last_res;
        r.is_empty   = (stack_top == STORE);
        r.free_bytes = stack_top[FREE_W-1:0];
        expected_results.push_back(r);
    endtask

    // Write the little-endian length header below the data and lower the top
    task automatic close_record();
        int unsigned hbase;
        hbase = stack_top - push_len - HDR;
        for (int i = 0; i < HDR; i++) begin
            if (hbase + i < STORE) begin
                mem_image[hbase + i] = push_len >> (8 * i);
            end
        end
        stack_top   = hbase;
        push_active = 1'b0;
        push_left   = 0;
    endtask

    task automatic model_request(input logic [REQ_W-1:0] kind, input int unsigned rlen,
                                 input logic [BYTE_W-1:0] dbyte, input int unsigned mlen);
        int unsigned stored;
        int unsigned n;
        int unsigned base;
        stored = 0;
        case (kind)
            REQ_PUSH_START: begin
                if (push_active) begin
                    queue_result(ST_SEQ, '0, 1'b0, 1'b1);
                end else if (rlen > MAX_REC || stack_top < rlen + HDR) begin
                    queue_result(ST_FULL, '0, 1'b0, 1'b1);
                end else begin
                    push_len    = rlen;
                    push_left   = rlen;
                    write_ptr   = stack_top - rlen;
                    push_active = 1'b1;
                    if (rlen == 0) begin
                        close_record();
                    end
                    queue_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            REQ_PUSH_DATA: begin
                if (!push_active) begin
                    queue_result(ST_SEQ, '0, 1'b0, 1'b1);
                end else begin
                    if (write_ptr < STORE) begin
                        mem_image[write_ptr] = dbyte;
                    end
                    write_ptr++;
                    push_left--;
                    if (push_left == 0) begin
                        close_record();
                    end
                    queue_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (push_active) begin
                    queue_result(ST_SEQ, '0, 1'b0, 1'b1);
                end else if (stack_top == STORE) begin
                    queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < HDR; i++) begin
                        stored |= int'(mem_at(stack_top + i)) << (8 * i);
                    end
                    if (mlen > MAX_REC) begin
                        mlen = MAX_REC;
                    end
                    n    = (stored < mlen) ? stored : mlen;
                    base = stack_top + HDR;
                    // Pop drops the whole record, saturating at the store end
                    if (kind == REQ_POP) begin
                        stack_top = (base + stored > STORE) ? STORE : base + stored;
                    end
                    if (n == 0) begin
                        queue_result(ST_OK, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            queue_result(ST_OK, mem_at(base + i), 1'b1, (i + 1 == n));
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                model_clear();
                queue_result(ST_OK, '0, 1'b0, 1'b1);
            end
            default: begin
                queue_result(ST_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] rlen,
                            input logic [BYTE_W-1:0] dbyte, input logic [LEN_W-1:0] mlen);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, mlen, dbyte, rlen};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_request(kind, rlen, dbyte, mlen);
    endtask

    // Drop valid after the last request of a stretch
    task automatic stop_requests();
        s_tvalid <= 1'b0;
    endtask

    task automatic push_record(input int unsigned len);
        send_req(REQ_PUSH_START, len, $urandom_range(0, 255), $urandom_range(0, 127));
        while (push_active) begin
            send_req(REQ_PUSH_DATA, $urandom_range(0, 127), $urandom_range(0, 255),
                     $urandom_range(0, 127));
        end
    endtask

    task automatic read_req(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] mlen);
        send_req(kind, $urandom_range(0, 127), $urandom_range(0, 255), mlen);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [FREE_W-1:0] want,
                               input logic [FREE_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        stack_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with none expected: tdata=%h tuser=%h tlast=%b",
                           m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_tuser[1:0]);
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_tuser[2]);
                    check_field("last_result", want.last_res, m_tlast);
                    check_field("is_empty", want.is_empty, m_tdata[8]);
                    check_field("free_bytes", want.free_bytes, m_tdata[19:9]);
                    check_field("tdata_pad", '0, m_tdata[23:20]);
                end
            end
        end
    end

    // Result ready: random gaps, plus a long hold-off on request from a test
    initial begin
        int gap_left;
        int hold_left;
        int hold_seen;
        gap_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (m_tvalid && m_tready) begin
                gap_left = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_and_stray();
        read_req(REQ_POP, 7'd64);
        read_req(REQ_PEEK, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'hFF, 7'd127);
        send_req(REQ_UNUSED_FIRST, 7'd127, 8'h00, 7'd0);
        send_req(3'd6, 7'd0, 8'hFF, 7'd127);
        send_req(REQ_UNUSED_LAST, 7'd64, 8'h5A, 7'd64);
        send_req(REQ_CLEAR, 7'd127, 8'hFF, 7'd127);
    endtask

    task automatic test_zero_length_record();
        send_req(REQ_PUSH_START, 7'd0, 8'h00, 7'd0);
        read_req(REQ_PEEK, 7'd64);
        read_req(REQ_POP, 7'd0);
        read_req(REQ_PEEK, 7'd1);
    endtask

    task automatic test_truncation();
        send_req(REQ_PUSH_START, 7'd3, 8'h00, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'h00, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'hFF, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'hA5, 7'd0);
        push_record(1);
        read_req(REQ_PEEK, 7'd127);
        read_req(REQ_POP, 7'd0);
        read_req(REQ_PEEK, 7'd1);
        read_req(REQ_PEEK, 7'd100);
        read_req(REQ_POP, 7'd65);
    endtask

    task automatic test_sequence_errors();
        send_req(REQ_PUSH_START, 7'd2, 8'h00, 7'd0);
        send_req(REQ_PUSH_START, 7'd1, 8'h00, 7'd0);
        read_req(REQ_POP, 7'd64);
        read_req(REQ_PEEK, 7'd64);
        send_req(REQ_PUSH_DATA, 7'd0, 8'h81, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'h7E, 7'd0);
        send_req(REQ_PUSH_START, 7'd5, 8'h00, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'h33, 7'd0);
        // Clear abandons the open push and the record below it
        send_req(REQ_CLEAR, 7'd0, 8'h00, 7'd0);
        send_req(REQ_PUSH_DATA, 7'd0, 8'h44, 7'd0);
        read_req(REQ_PEEK, 7'd64);
    endtask

    task automatic test_oversized_record();
        send_req(REQ_PUSH_START, 7'd65, 8'h00, 7'd0);
        send_req(REQ_PUSH_START, 7'd127, 8'h00, 7'd0);
    endtask

    // Hold the result side while requests keep coming so the block backs up
    task automatic test_backpressure();
        send_req(REQ_CLEAR, 7'd0, 8'h00, 7'd0);
        push_record(40);
        burst_mode    <= 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (6) read_req(REQ_PEEK, 7'd64);
        read_req(REQ_POP, 7'd64);
        push_record(3);
        read_req(REQ_POP, 7'd64);
        burst_mode <= 1'b0;
    endtask

    // Fill the store to zero free bytes, then drain it
    task automatic test_fill_and_drain();
        send_req(REQ_CLEAR, 7'd0, 8'h00, 7'd0);
        burst_mode <= 1'b1;
        repeat (15) push_record(MAX_REC);
        burst_mode <= 1'b0;
        send_req(REQ_PUSH_START, 7'd1, 8'h00, 7'd0);
        push_record(0);
        send_req(REQ_PUSH_START, 7'd0, 8'h00, 7'd0);
        send_req(REQ_PUSH_START, 7'd64, 8'h00, 7'd0);
        read_req(REQ_PEEK, 7'd64);
        read_req(REQ_POP, 7'd64);
        read_req(REQ_PEEK, 7'd64);
        while (stack_top != STORE) begin
            read_req(REQ_POP, $urandom_range(0, 127));
        end
        read_req(REQ_POP, 7'd64);
    endtask

    task automatic test_random_traffic();
        int sent;
        int r;
        int unsigned len;
        logic [REQ_W-1:0] noise_kind;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // Push sequence, sometimes broken by an interloper
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    len = $urandom_range(0, 12);
                end else if (r < 95) begin
                    len = $urandom_range(13, MAX_REC);
                end else begin
                    len = $urandom_range(MAX_REC + 1, 127);
                end
                send_req(REQ_PUSH_START, len, $urandom_range(0, 255), $urandom_range(0, 127));
                sent++;
                while (push_active) begin
                    if ($urandom_range(0, 29) == 0) begin
                        noise_kind = $urandom_range(REQ_PUSH_START, REQ_CLEAR);
                        if (noise_kind == REQ_PUSH_DATA) begin
                            noise_kind = REQ_POP;
                        end
                        send_req(noise_kind, $urandom_range(0, 127), $urandom_range(0, 255),
                                 $urandom_range(0, 127));
                    end else begin
                        send_req(REQ_PUSH_DATA, $urandom_range(0, 127), $urandom_range(0, 255),
                                 $urandom_range(0, 127));
                    end
                    sent++;
                end
            end else if (r < 80) begin
                read_req($urandom_range(0, 1) ? REQ_POP : REQ_PEEK,
                         $urandom_range(0, 1) ? 7'(MAX_REC) : 7'($urandom_range(0, 127)));
                sent++;
            end else if (r < 85) begin
                send_req(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 255),
                         $urandom_range(0, 127));
                sent++;
            end else if (r < 93) begin
                send_req(REQ_PUSH_DATA, $urandom_range(0, 127), $urandom_range(0, 255),
                         $urandom_range(0, 127));
            end else begin
                send_req($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST),
                         $urandom_range(0, 127), $urandom_range(0, 255),
                         $urandom_range(0, 127));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        for (int i = 0; i < STORE; i++) begin
            mem_image[i] = '0;
        end
        model_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_stray();
        test_zero_length_record();
        test_truncation();
        test_sequence_errors();
        test_oversized_record();
        test_backpressure();
        test_fill_and_drain();
        test_random_traffic();
        stop_requests();

        // Drain outstanding results, then allow for any trailing activity
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: variable_record_stack_core.f
src/vrs_pkg.sv
src/vrs_store.sv
src/variable_record_stack_core.sv
bench/variable_record_stack_core_tb.sv
